// ===== sv/sds_pkg.sv =====
// ============================================================================
// sds_pkg
// Types, constants and segment tables shared by the serial display driver.
// ============================================================================
`default_nettype none

package sds_pkg;

    // Widest bit run one character can cause: start + 15 code + 2 select + 4 pad
    localparam int unsigned RUN_BITS    = 22;
    localparam int unsigned LEN_W       = 5;
    localparam int unsigned CODE_W      = 15;
    localparam int unsigned SEG7_BITS   = 7;
    localparam int unsigned SEG14_BITS  = 15;
    localparam int unsigned TAIL_BITS   = 6;

    localparam logic MODE_SEG7  = 1'b0;
    localparam logic MODE_SEG14 = 1'b1;

    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_Z  = 8'h7A;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CASE_FOLD = 8'h20;

    typedef struct packed {
        logic [7:0] char_code;
        logic       first_char;
        logic       last_char;
    } t_in_item;

    typedef struct packed {
        logic data_bit;
        logic run_end;
    } t_out_item;

    // One queued run of serial bits, LSB sent first
    typedef struct packed {
        logic [RUN_BITS-1:0] bits;
        logic [LEN_W-1:0]    len;
    } t_run;

    function automatic logic [CODE_W-1:0] seg7_digit(input logic [3:0] idx);
        logic [CODE_W-1:0] c;
        case (idx)
            4'd0: c = 15'h003F;
            4'd1: c = 15'h0006;
            4'd2: c = 15'h005B;
            4'd3: c = 15'h004F;
            4'd4: c = 15'h0066;
            4'd5: c = 15'h006D;
            4'd6: c = 15'h007D;
            4'd7: c = 15'h0007;
            4'd8: c = 15'h007F;
            4'd9: c = 15'h006F;
            default: c = '0;
        endcase
        return c;
    endfunction

    function automatic logic [CODE_W-1:0] seg14_digit(input logic [3:0] idx);
        logic [CODE_W-1:0] c;
        case (idx)
            4'd0: c = 15'h003F;
            4'd1: c = 15'h0006;
            4'd2: c = 15'h111B;
            4'd3: c = 15'h110F;
            4'd4: c = 15'h1126;
            4'd5: c = 15'h112D;
            4'd6: c = 15'h113C;
            4'd7: c = 15'h1981;
            4'd8: c = 15'h113F;
            4'd9: c = 15'h1127;
            default: c = '0;
        endcase
        return c;
    endfunction

    function automatic logic [CODE_W-1:0] seg14_letter(input logic [4:0] idx);
        logic [CODE_W-1:0] c;
        case (idx)
            5'd0:  c = 15'h1137;
            5'd1:  c = 15'h054F;
            5'd2:  c = 15'h0039;
            5'd3:  c = 15'h044F;
            5'd4:  c = 15'h1139;
            5'd5:  c = 15'h1131;
            5'd6:  c = 15'h013D;
            5'd7:  c = 15'h1136;
            5'd8:  c = 15'h0449;
            5'd9:  c = 15'h001E;
            5'd10: c = 15'h12B0;
            5'd11: c = 15'h0038;
            5'd12: c = 15'h20B6;
            5'd13: c = 15'h2236;
            5'd14: c = 15'h003F;
            5'd15: c = 15'h1133;
            5'd16: c = 15'h023F;
            5'd17: c = 15'h1333;
            5'd18: c = 15'h112D;
            5'd19: c = 15'h0441;
            5'd20: c = 15'h003E;
            5'd21: c = 15'h2206;
            5'd22: c = 15'h0A36;
            5'd23: c = 15'h2A80;
            5'd24: c = 15'h2480;
            5'd25: c = 15'h0889;
            default: c = '0;
        endcase
        return c;
    endfunction

    // Fold to upper case, then look up; anything without a pattern is blank
    function automatic logic [CODE_W-1:0] lookup_code(input logic [7:0] ch,
                                                      input logic       mode);
        logic [7:0]        up;
        logic [7:0]        dig;
        logic [7:0]        let_idx;
        logic [CODE_W-1:0] c;
        up = ch;
        if (ch >= CH_LOW_A && ch <= CH_LOW_Z) begin
            up = ch - CASE_FOLD;
        end
        dig     = up - CH_ZERO;
        let_idx = up - CH_UP_A;
        c       = '0;
        if (up >= CH_ZERO && up <= CH_NINE) begin
            c = (mode == MODE_SEG14) ? seg14_digit(dig[3:0]) : seg7_digit(dig[3:0]);
        end else if (mode == MODE_SEG14 && up >= CH_UP_A && up <= CH_UP_Z) begin
            c = seg14_letter(let_idx[4:0]);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== sv/sds_front.sv =====
// ============================================================================
// sds_front
// Accepts characters, looks up the segment code and packs the bit run.
// ============================================================================
`default_nettype none

module sds_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_wdata,
    input  wire logic              i_valid,
    input  wire sds_pkg::t_in_item i_item,
    input  wire logic              i_full,
    output logic                   o_stall,
    output logic                   o_push,
    output sds_pkg::t_run          o_run
);

    logic                            r_display_type;
    logic                            r_right_half;
    logic                            n_right_half;
    logic                            accept;
    logic                            tail_en;
    logic [sds_pkg::CODE_W-1:0]      code;
    logic [sds_pkg::RUN_BITS-2:0]    body;
    logic [sds_pkg::LEN_W-1:0]       len;

    assign o_stall = i_full;
    assign accept  = i_valid & ~i_full;
    assign o_push  = accept;

    assign code    = sds_pkg::lookup_code(i_item.char_code, r_display_type);
    assign tail_en = (r_display_type == sds_pkg::MODE_SEG14) & i_item.last_char;

    // Code, then select pair (left 0,1 / right 1,0), then four zero pad bits
    assign body = {4'b0000, tail_en & ~r_right_half, tail_en & r_right_half, code};

    always_comb begin
        len = (r_display_type == sds_pkg::MODE_SEG14)
            ? sds_pkg::LEN_W'(sds_pkg::SEG14_BITS)
            : sds_pkg::LEN_W'(sds_pkg::SEG7_BITS);
        if (tail_en) begin
            len = len + sds_pkg::LEN_W'(sds_pkg::TAIL_BITS);
        end
        if (i_item.first_char) begin
            len = len + sds_pkg::LEN_W'(1);
            o_run.bits = {body, 1'b1};
        end else begin
            o_run.bits = {1'b0, body};
        end
        o_run.len = len;
    end

    always_comb begin
        n_right_half = r_right_half;
        if (accept && tail_en) begin
            n_right_half = ~r_right_half;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_display_type <= sds_pkg::MODE_SEG7;
            r_right_half   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_display_type <= i_cfg_wdata;
            end
            r_right_half <= n_right_half;
        end
    end

endmodule

`default_nettype wire

// ===== sv/sds_queue.sv =====
// ============================================================================
// sds_queue
// Small FIFO of packed bit runs between the front and the serializer.
// ============================================================================
`default_nettype none

module sds_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire sds_pkg::t_run i_run,
    input  wire logic          i_pop,
    output logic               o_full,
    output logic               o_empty,
    output sds_pkg::t_run      o_run
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    sds_pkg::t_run   r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_run   = r_mem[r_rd_ptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
        logic [PW-1:0] q;
        q = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
        return q;
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= wrap_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= wrap_inc(r_rd_ptr);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== sv/sds_back.sv =====
// ============================================================================
// sds_back
// Shifts queued bit runs out one bit per transaction, flagging the run end.
// ============================================================================
`default_nettype none

module sds_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_empty,
    input  wire sds_pkg::t_run i_run,
    output logic               o_pop,
    input  wire logic          i_stall,
    output logic               o_valid,
    output sds_pkg::t_out_item o_item
);

    logic                           r_valid;
    logic [sds_pkg::RUN_BITS-1:0]   r_shift;
    logic [sds_pkg::LEN_W-1:0]      r_left;
    logic                           xfer;
    logic                           last_bit;
    logic                           want;

    assign xfer     = r_valid & ~i_stall;
    assign last_bit = (r_left == sds_pkg::LEN_W'(1));
    assign want     = ~r_valid | (xfer & last_bit);
    assign o_pop    = want & ~i_empty;

    assign o_valid       = r_valid;
    assign o_item.data_bit = r_shift[0];
    assign o_item.run_end  = last_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (want) begin
            r_valid <= ~i_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_shift <= i_run.bits;
            r_left  <= i_run.len;
        end else if (xfer) begin
            r_shift <= {1'b0, r_shift[sds_pkg::RUN_BITS-1:1]};
            r_left  <= r_left - sds_pkg::LEN_W'(1);
        end
    end

endmodule

`default_nettype wire

// ===== sv/segment_display_serializer.sv =====
// ============================================================================
// segment_display_serializer
// Character to serial bit stream driver for shift-register segment displays.
// ============================================================================
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-------------------------
//  cfg     | in        | i_cfg_we                 | i_cfg_wdata (display_type)
//  char in | in        | i_in_valid / o_in_stall  | i_in_item  (t_in_item)
//  bit out | out       | o_out_valid / i_out_stall| o_out_item (t_out_item)
//
//  Each character transaction yields 7 to 22 bit transactions, one per cycle
//  while the output is not stalled; the serializer shift register sets the
//  sustained character rate.
//  The front packs a whole run in the cycle it accepts a character and pushes
//  it into the queue, so intake continues while earlier runs shift out.
//  Reset (synchronous, active low) clears the mode to 7-segment, the select
//  half to left and empties the queue and the serializer.
//  An output stall holds the current bit; input stalls only when the queue
//  is full.
//
`default_nettype none

module segment_display_serializer #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_wdata,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire sds_pkg::t_in_item  i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output sds_pkg::t_out_item      o_out_item
);

    logic          q_push;
    logic          q_pop;
    logic          q_full;
    logic          q_empty;
    sds_pkg::t_run front_run;
    sds_pkg::t_run head_run;

    // Classify the character, track the select half, build the bit run
    sds_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_in_valid),
        .i_item      (i_in_item),
        .i_full      (q_full),
        .o_stall     (o_in_stall),
        .o_push      (q_push),
        .o_run       (front_run)
    );

    // Decouple intake from serialization
    sds_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_run   (front_run),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_run   (head_run)
    );

    // Shift each run out LSB first; reload from the queue on the last bit
    sds_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_run   (head_run),
        .o_pop   (q_pop),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_item  (o_out_item)
    );

endmodule

`default_nettype wire

// ===== sim/segment_display_serializer_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// segment_display_serializer_tb
// Self-checking bench for the serial segment display driver. Character
// transactions go in through a queue-fed driver. A scoreboard works out the
// serial bit stream for every accepted character and checks each bit
// transaction that leaves the block. Both sides stall at random.
// ============================================================================

module segment_display_serializer_tb;

    localparam int unsigned STALL_PCT     = 12;
    localparam int unsigned IDLE_LIMIT    = 2000;
    localparam int unsigned SETTLE_CYCLES = 30;
    localparam int unsigned PHASE_CHARS   = 65;
    localparam int unsigned NUM_PHASES    = 6;

    // Segment patterns packed with entry 0 in the low 15 bits
    localparam logic [10*15-1:0] SEG7_DIGITS = {
        15'h006F, 15'h007F, 15'h0007, 15'h007D, 15'h006D,
        15'h0066, 15'h004F, 15'h005B, 15'h0006, 15'h003F
    };
    localparam logic [10*15-1:0] SEG14_DIGITS = {
        15'h1127, 15'h113F, 15'h1981, 15'h113C, 15'h112D,
        15'h1126, 15'h110F, 15'h111B, 15'h0006, 15'h003F
    };
    localparam logic [26*15-1:0] SEG14_LETTERS = {
        15'h0889, 15'h2480, 15'h2A80, 15'h0A36, 15'h2206, 15'h003E,
        15'h0441, 15'h112D, 15'h1333, 15'h023F, 15'h1133, 15'h003F,
        15'h2236, 15'h20B6, 15'h0038, 15'h12B0, 15'h001E, 15'h0449,
        15'h1136, 15'h013D, 15'h1131, 15'h1139, 15'h044F, 15'h0039,
        15'h054F, 15'h1137
    };

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_cfg_we    = 1'b0;
    logic               i_cfg_wdata = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_stall;
    sds_pkg::t_in_item  i_in_item   = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    sds_pkg::t_out_item o_out_item;

    // Predictor state: display mode and the select half sent next
    logic      disp_mode  = sds_pkg::MODE_SEG7;
    logic      right_half = 1'b0;

    sds_pkg::t_in_item  pending_chars[$];
    sds_pkg::t_out_item expected_bits[$];

    bit        quiet       = 1'b0;
    int        err_count   = 0;
    int        n_chars     = 0;
    int        n_chars14   = 0;
    int        n_full_runs = 0;
    int        n_bits      = 0;
    int        n_mode_wr   = 0;
    int        idle_cycles = 0;

    segment_display_serializer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always #1 i_clk = ~i_clk;

    // Roll for an idle or stall cycle; never idle inside the quiet stretch
    function automatic bit idle_roll();
        return !quiet && ($urandom_range(99) < STALL_PCT);
    endfunction

    task automatic report_mismatch(input string what);
        err_count++;
        $display("[%0t] MISMATCH after %0d bits: %s", $time, n_bits, what);
    endtask

    // Work out the serial bits one accepted character causes and queue them
    task automatic serialize_char(input sds_pkg::t_in_item it);
        logic [7:0]                   up;
        logic [sds_pkg::CODE_W-1:0]   code;
        logic [sds_pkg::RUN_BITS-1:0] run;
        int                           len;
        int                           nbits;
        int                           i;
        sds_pkg::t_out_item           b;
        up = it.char_code;
        if (up >= sds_pkg::CH_LOW_A && up <= sds_pkg::CH_LOW_Z) begin
            up = up - sds_pkg::CASE_FOLD;
        end
        code = '0;
        if (up >= sds_pkg::CH_ZERO && up <= sds_pkg::CH_NINE) begin
            if (disp_mode == sds_pkg::MODE_SEG14) begin
                code = SEG14_DIGITS[int'(up - sds_pkg::CH_ZERO) * 15 +: 15];
            end else begin
                code = SEG7_DIGITS[int'(up - sds_pkg::CH_ZERO) * 15 +: 15];
            end
        end else if (disp_mode == sds_pkg::MODE_SEG14 && up >= sds_pkg::CH_UP_A
                     && up <= sds_pkg::CH_UP_Z) begin
            code = SEG14_LETTERS[int'(up - sds_pkg::CH_UP_A) * 15 +: 15];
        end
        nbits = (disp_mode == sds_pkg::MODE_SEG14) ? sds_pkg::SEG14_BITS
                                                   : sds_pkg::SEG7_BITS;
        run   = '0;
        len   = 0;
        if (it.first_char) begin
            run[len] = 1'b1;
            len++;
        end
        for (i = 0; i < nbits; i++) begin
            run[len] = code[i];
            len++;
        end
        // Frame end in 14-segment mode: select pair, four zero pads, flip half
        if (disp_mode == sds_pkg::MODE_SEG14 && it.last_char) begin
            run[len]     = right_half;
            run[len + 1] = ~right_half;
            len          = len + 6;
            right_half   = ~right_half;
        end
        for (i = 0; i < len; i++) begin
            b.data_bit = run[i];
            b.run_end  = (i == len - 1);
            expected_bits.push_back(b);
        end
        n_chars++;
        if (disp_mode == sds_pkg::MODE_SEG14) begin
            n_chars14++;
        end
        if (len == sds_pkg::RUN_BITS) begin
            n_full_runs++;
        end
    endtask

    // ------------------------------------------------------------------
    // Character driver: present the next pending transaction once the
    // current one is taken, hold the payload while stalled.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (pending_chars.size() > 0 && !idle_roll()) begin
                i_in_item  <= pending_chars.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Output side: stall at random, independent of valid
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= idle_roll();
        end
    end

    // ------------------------------------------------------------------
    // Scoreboard: predict on every accepted character, check every
    // accepted bit, track the mode register, and run the watchdog.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : scoreboard
        sds_pkg::t_out_item want;
        bit                 moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (i_in_valid && !o_in_stall) begin
                serialize_char(i_in_item);
                moved = 1'b1;
            end
            // Apply the mode write after prediction; writes only land when idle
            if (i_cfg_we) begin
                disp_mode = i_cfg_wdata;
            end
            if (o_out_valid && !i_out_stall) begin
                moved = 1'b1;
                if (expected_bits.size() == 0) begin
                    report_mismatch("bit transaction with nothing expected");
                end else begin
                    want = expected_bits.pop_front();
                    if (o_out_item.data_bit !== want.data_bit) begin
                        report_mismatch($sformatf("data_bit %b, expected %b",
                                                  o_out_item.data_bit, want.data_bit));
                    end
                    if (o_out_item.run_end !== want.run_end) begin
                        report_mismatch($sformatf("run_end %b, expected %b",
                                                  o_out_item.run_end, want.run_end));
                    end
                end
                n_bits++;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[%0t] no transaction for %0d cycles, %0d bits still expected",
                         $time, IDLE_LIMIT, expected_bits.size());
                $display("segment_display_serializer_tb: FAIL");
                $finish;
            end
        end
    end

    task automatic queue_char(input logic [7:0] ch, input logic f, input logic l);
        sds_pkg::t_in_item it;
        it.char_code  = ch;
        it.first_char = f;
        it.last_char  = l;
        pending_chars.push_back(it);
    endtask

    // Write the mode register on one clock edge; call only while idle
    task automatic write_mode(input logic m);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(negedge i_clk);
        n_mode_wr++;
    endtask

    // Hold until every queued character is taken and every bit has come out
    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (pending_chars.size() != 0 || i_in_valid || expected_bits.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    // Mostly well-formed frames of random text, some with random frame flags
    task automatic queue_frames(input int count);
        int         added;
        int         flen;
        int         k;
        bit         noisy;
        logic [7:0] ch;
        logic       f;
        logic       l;
        added = 0;
        while (added < count) begin
            flen  = $urandom_range(6, 1);
            noisy = ($urandom_range(99) < 15);
            for (k = 0; k < flen; k++) begin
                case ($urandom_range(9))
                    0, 1, 2: ch = sds_pkg::CH_ZERO + 8'($urandom_range(9));
                    3, 4:    ch = sds_pkg::CH_UP_A + 8'($urandom_range(25));
                    5, 6:    ch = sds_pkg::CH_LOW_A + 8'($urandom_range(25));
                    default: ch = 8'($urandom_range(255));
                endcase
                f = noisy ? 1'($urandom_range(1)) : (k == 0);
                l = noisy ? 1'($urandom_range(1)) : (k == flen - 1);
                queue_char(ch, f, l);
                added++;
            end
        end
    endtask

    initial begin
        int p;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // 7-segment: digit extremes, blank letter, code above 127, both flags
        write_mode(sds_pkg::MODE_SEG7);
        queue_char(sds_pkg::CH_ZERO, 1'b1, 1'b0);
        queue_char(sds_pkg::CH_NINE, 1'b0, 1'b0);
        queue_char(sds_pkg::CH_LOW_A, 1'b0, 1'b0);
        queue_char(8'hFF, 1'b0, 1'b1);
        queue_char("5", 1'b1, 1'b1);
        wait_drained();

        // 14-segment: letter and digit extremes in both cases, both halves,
        // the 22-bit run, characters just outside the lookup ranges
        write_mode(sds_pkg::MODE_SEG14);
        queue_char(sds_pkg::CH_UP_A, 1'b1, 1'b0);
        queue_char(sds_pkg::CH_LOW_Z, 1'b0, 1'b0);
        queue_char(sds_pkg::CH_UP_Z, 1'b0, 1'b0);
        queue_char(sds_pkg::CH_ZERO, 1'b0, 1'b0);
        queue_char(sds_pkg::CH_NINE, 1'b0, 1'b1);
        queue_char("m", 1'b1, 1'b1);
        queue_char("X", 1'b1, 1'b1);
        queue_char(8'h00, 1'b0, 1'b0);
        queue_char(8'h80, 1'b1, 1'b0);
        queue_char("7", 1'b0, 1'b1);
        queue_char("@", 1'b1, 1'b0);
        queue_char("[", 1'b0, 1'b0);
        // grave accent, just below lower-case a
        queue_char(8'h60, 1'b0, 1'b0);
        queue_char("{", 1'b0, 1'b1);
        queue_char("/", 1'b1, 1'b0);
        queue_char(":", 1'b0, 1'b0);
        // Leave a frame open so the next mode takes over mid-frame
        queue_char("Q", 1'b1, 1'b0);
        wait_drained();

        // Random phases alternate the mode; one runs with no idling at all
        for (p = 0; p < NUM_PHASES; p++) begin
            write_mode((p % 2 == 0) ? sds_pkg::MODE_SEG7 : sds_pkg::MODE_SEG14);
            quiet = (p == 3);
            queue_frames(PHASE_CHARS);
            wait_drained();
        end
        quiet = 1'b0;
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("covered %0d characters (%0d in 14-segment mode, %0d full 22-bit runs)",
                 n_chars, n_chars14, n_full_runs);
        $display("checked %0d serial bits across %0d mode register writes",
                 n_bits, n_mode_wr);
        if (err_count == 0 && expected_bits.size() == 0) begin
            $display("segment_display_serializer_tb: PASS");
        end else begin
            $display("segment_display_serializer_tb: FAIL");
        end
        $finish;
    end

endmodule
